// ===== sv/icst_pkg.sv =====
// Shared types and constants of the counted multiset table.
package icst_pkg;

	localparam int KIND_W     = 3;
	localparam int KEY_W      = 32;
	localparam int AMOUNT_W   = 32;
	localparam int COUNT_W    = 32;
	localparam int DISTINCT_W = 6;

	localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SUB    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_SWEEP  = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

endpackage

// ===== sv/icst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module icst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/integer_counted_set_table.sv =====
// Counted multiset table: top level with scan sequencer and update logic.
//
// Usage: each input transaction (kind, key, amount) performs one operation
// on a table of up to CAPACITY keys and yields exactly one output
// transaction (status, found, key_count, distinct_keys). Kinds are add,
// subtract, remove, query and clear all; codes 5 to 7 act as a query.
// Both channels use valid/ready. The block works on one transaction at a
// time: in_ready is high only while the sequencer is idle.
// A lookup reads the key and count memories one slot per cycle, over the
// slots taken so far (at most CAPACITY); a hit ends the scan early. Clear
// all sweeps the taken slots one per cycle.
// The next transaction is accepted in the cycle after the result is
// registered, even if that result is still waiting to be taken.
// If the receiver stalls, the finished result stays in the output register
// and a following operation waits in its update step until it is taken.
// Reset empties the table (no slots taken, no nonzero keys) at once; the
// memories themselves are not cleared, since only taken slots are read.
module integer_counted_set_table #(
	parameter int CAPACITY   = 32,
	parameter int KEY_BITS   = 32,
	parameter int COUNT_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [icst_pkg::KIND_W-1:0]           kind,
	input  logic signed [icst_pkg::KEY_W-1:0]     key,
	input  logic [icst_pkg::AMOUNT_W-1:0]         amount,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  status,
	output logic                                  found,
	output logic [icst_pkg::COUNT_W-1:0]          key_count,
	output logic [icst_pkg::DISTINCT_W-1:0]       distinct_keys
);

	import icst_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = ((COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W) + 1;
	localparam int NX = CW + DISTINCT_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	state_t                state_q;
	logic [KIND_W-1:0]     kind_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [AMOUNT_W-1:0]   amount_q;
	logic [CW-1:0]         used_q;
	logic [CW-1:0]         nz_q;
	logic [CW-1:0]         rd_q;
	logic                  cmp_v_q;
	logic [AW-1:0]         cmp_idx_q;
	logic                  hit_q;
	logic [AW-1:0]         slot_q;
	logic [COUNT_BITS-1:0] old_q;
	logic                  out_valid_q;
	logic                  status_q;
	logic                  found_q;
	logic [COUNT_W-1:0]    key_count_q;
	logic [DISTINCT_W-1:0] distinct_q;

	logic [KEY_BITS-1:0]   key_x;
	logic [KEY_BITS-1:0]   key_rdata;
	logic [COUNT_BITS-1:0] cnt_rdata;
	logic                  match;
	logic                  scan_issue;
	logic                  upd_go;
	logic                  key_we;
	logic                  cnt_we;
	logic [AW-1:0]         cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;

	// Update step results.
	logic [SW-1:0]         sum_w;
	logic [SW-1:0]         amt_w;
	logic [SW-1:0]         diff_w;
	logic [COUNT_BITS-1:0] add_sat;
	logic [COUNT_BITS-1:0] new_sat;
	logic [COUNT_BITS-1:0] res_cnt;
	logic                  upd_we;
	logic                  upd_new;
	logic                  upd_status;
	logic [CW-1:0]         nz_n;
	logic [CW-1:0]         used_n;
	logic [SW-1:0]         res_w;
	logic [NX-1:0]         nz_x;

	// The table keeps the low KEY_BITS bits of the sign-extended key.
	always_comb begin
		for (int b = 0; b < KEY_BITS; b++) begin
			key_x[b] = key[(b < KEY_W) ? b : KEY_W - 1];
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign match      = cmp_v_q && (key_rdata == key_q);
	assign scan_issue = (state_q == ST_SCAN) && !match && (rd_q != used_q);
	assign upd_go     = (state_q == ST_UPDATE) && (!out_valid_q || out_ready);

	always_comb begin
		sum_w   = SW'(old_q) + SW'(amount_q);
		amt_w   = SW'(amount_q);
		diff_w  = SW'(old_q) - amt_w;
		add_sat = (sum_w > SW'(COUNT_MAX)) ? COUNT_MAX : sum_w[COUNT_BITS-1:0];
		new_sat = (amt_w > SW'(COUNT_MAX)) ? COUNT_MAX : amt_w[COUNT_BITS-1:0];

		res_cnt    = '0;
		upd_we     = 1'b0;
		upd_new    = 1'b0;
		upd_status = STATUS_DONE;
		nz_n       = nz_q;
		used_n     = used_q;

		unique case (kind_q)
			KIND_ADD: begin
				if (hit_q) begin
					res_cnt = add_sat;
					upd_we  = 1'b1;
					if (old_q == '0 && add_sat != '0) begin
						nz_n = nz_q + CW'(1);
					end
				end else if (amount_q != '0) begin
					if (used_q == CW'(CAPACITY)) begin
						upd_status = STATUS_FULL;
					end else begin
						res_cnt = new_sat;
						upd_new = 1'b1;
						nz_n    = nz_q + CW'(1);
						used_n  = used_q + CW'(1);
					end
				end
			end
			KIND_SUB: begin
				if (hit_q && old_q != '0) begin
					upd_we = 1'b1;
					if (amt_w >= SW'(old_q)) begin
						res_cnt = '0;
						nz_n    = nz_q - CW'(1);
					end else begin
						res_cnt = diff_w[COUNT_BITS-1:0];
					end
				end
			end
			KIND_REMOVE: begin
				if (hit_q && old_q != '0) begin
					upd_we = 1'b1;
					nz_n   = nz_q - CW'(1);
				end
			end
			KIND_CLEAR: begin
				nz_n = '0;
			end
			default: begin
				if (hit_q) begin
					res_cnt = old_q;
				end
			end
		endcase

		res_w = SW'(res_cnt);
		nz_x  = NX'(nz_n);
	end

	// Write port of the count memory is shared by the sweep and the update.
	always_comb begin
		key_we    = upd_go && upd_new;
		cnt_we    = 1'b0;
		cnt_waddr = slot_q;
		cnt_wdata = res_cnt;
		if (state_q == ST_SWEEP) begin
			cnt_we    = (rd_q != used_q);
			cnt_waddr = rd_q[AW-1:0];
			cnt_wdata = '0;
		end else if (upd_go) begin
			cnt_we = upd_we || upd_new;
			if (upd_new) begin
				cnt_waddr = used_q[AW-1:0];
			end
		end
	end

	icst_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(CAPACITY)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(used_q[AW-1:0]),
		.wdata(key_q),
		.re   (scan_issue),
		.raddr(rd_q[AW-1:0]),
		.rdata(key_rdata)
	);

	icst_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(CAPACITY)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.re   (scan_issue),
		.raddr(rd_q[AW-1:0]),
		.rdata(cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			nz_q        <= '0;
			rd_q        <= '0;
			cmp_v_q     <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may replace one that is taken in the same cycle.
			if (upd_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					rd_q    <= '0;
					cmp_v_q <= 1'b0;
					hit_q   <= 1'b0;
					if (in_valid) begin
						state_q <= (kind == KIND_CLEAR) ? ST_SWEEP : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// One slot is read per cycle; its key is compared in the next cycle.
					cmp_v_q <= scan_issue;
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= ST_UPDATE;
					end else if (rd_q == used_q) begin
						state_q <= ST_UPDATE;
					end else begin
						rd_q <= rd_q + CW'(1);
					end
				end
				ST_SWEEP: begin
					if (rd_q == used_q) begin
						state_q <= ST_UPDATE;
					end else begin
						rd_q <= rd_q + CW'(1);
					end
				end
				ST_UPDATE: begin
					if (upd_go) begin
						nz_q    <= nz_n;
						used_q  <= used_n;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			kind_q   <= kind;
			key_q    <= key_x;
			amount_q <= amount;
		end
		if (scan_issue) begin
			cmp_idx_q <= rd_q[AW-1:0];
		end
		if (state_q == ST_SCAN && match) begin
			slot_q <= cmp_idx_q;
			old_q  <= cnt_rdata;
		end
		if (upd_go) begin
			status_q    <= upd_status;
			found_q     <= (res_cnt != '0);
			key_count_q <= (res_w > SW'({COUNT_W{1'b1}})) ? '1 : res_w[COUNT_W-1:0];
			distinct_q  <= (nz_x > NX'(63)) ? '1 : nz_x[DISTINCT_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign found         = found_q;
	assign key_count     = key_count_q;
	assign distinct_keys = distinct_q;

endmodule

// ===== sv/icst_chk.sv =====
// Port-level checker for the counted multiset table, bound to the top level.
module icst_chk (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic                                  status,
	input logic                                  found,
	input logic [icst_pkg::COUNT_W-1:0]          key_count,
	input logic [icst_pkg::DISTINCT_W-1:0]       distinct_keys
);

	import icst_pkg::*;

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_count) && $stable(status)
			&& $stable(found) && $stable(distinct_keys))
		else $error("output transaction changed while stalled");

	// Only one transaction is in work: acceptance drops ready.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while busy");

	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (found == (key_count != '0)))
		else $error("found disagrees with key_count");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !found && key_count == '0)
		else $error("full status with a nonzero count");

	a_found_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> distinct_keys != '0)
		else $error("key found while no key is nonzero");

endmodule

bind integer_counted_set_table icst_chk u_icst_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.found        (found),
	.key_count    (key_count),
	.distinct_keys(distinct_keys)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the counted multiset table.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import icst_pkg::*;

	localparam int SLOTS = 32;
	localparam int POOL_SIZE = 44;
	localparam int RANDOM_OPS = 1530;

	typedef struct packed {
		logic                  status;
		logic                  found;
		logic [COUNT_W-1:0]    count;
		logic [DISTINCT_W-1:0] live;
	} table_result_t;

	// Keeps its own copy of the key table and the results still owed by the block.
	class count_table_model;
		logic [KEY_W-1:0]   slot_key[SLOTS];
		logic [COUNT_W-1:0] slot_count[SLOTS];
		int unsigned        used_slots;
		int unsigned        live_keys;
		table_result_t      pending[$];
		int unsigned        errors;
		int unsigned        n_checked;
		int unsigned        n_full;

		function void note_op(logic [KIND_W-1:0] op, logic [KEY_W-1:0] k,
				logic [AMOUNT_W-1:0] amt);
			int                 slot;
			int                 i;
			logic [COUNT_W:0]   sum;
			logic [COUNT_W-1:0] nw;
			logic [COUNT_W-1:0] cnt;
			logic               stat;
			table_result_t      res;
			slot = -1;
			for (i = 0; i < used_slots; i++) begin
				if (slot < 0 && slot_key[i] == k)
					slot = i;
			end
			cnt = '0;
			stat = STATUS_DONE;
			case (op)
				KIND_ADD: begin
					if (slot >= 0) begin
						sum = {1'b0, slot_count[slot]} + {1'b0, amt};
						nw = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
						if (slot_count[slot] == '0 && nw != '0)
							live_keys++;
						slot_count[slot] = nw;
						cnt = nw;
					end else if (amt != '0) begin
						if (used_slots >= SLOTS) begin
							stat = STATUS_FULL;
						end else begin
							slot_key[used_slots] = k;
							slot_count[used_slots] = amt;
							used_slots++;
							live_keys++;
							cnt = amt;
						end
					end
				end
				KIND_SUB: begin
					if (slot >= 0) begin
						if (slot_count[slot] != '0) begin
							if (amt >= slot_count[slot]) begin
								slot_count[slot] = '0;
								live_keys--;
							end else begin
								slot_count[slot] = slot_count[slot] - amt;
							end
						end
						cnt = slot_count[slot];
					end
				end
				KIND_REMOVE: begin
					if (slot >= 0 && slot_count[slot] != '0) begin
						slot_count[slot] = '0;
						live_keys--;
					end
				end
				KIND_CLEAR: begin
					for (i = 0; i < used_slots; i++)
						slot_count[i] = '0;
					live_keys = 0;
				end
				default: begin
					// Query, and the unused codes which behave as a query.
					if (slot >= 0)
						cnt = slot_count[slot];
				end
			endcase
			res.status = stat;
			res.found = (cnt != '0);
			res.count = cnt;
			res.live = live_keys[DISTINCT_W-1:0];
			pending.push_back(res);
		endfunction

		function void compare_field(string name, logic [COUNT_W-1:0] exp_v,
				logic [COUNT_W-1:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(table_result_t act);
			table_result_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result transaction, expected none, got %p", $time, act);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			n_checked++;
			if (act.status === STATUS_FULL)
				n_full++;
			compare_field("status", COUNT_W'(exp_r.status), COUNT_W'(act.status));
			compare_field("found", COUNT_W'(exp_r.found), COUNT_W'(act.found));
			compare_field("key_count", exp_r.count, act.count);
			compare_field("distinct_keys", COUNT_W'(exp_r.live), COUNT_W'(act.live));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [KIND_W-1:0]     kind = '0;
	logic signed [KEY_W-1:0] key = '0;
	logic [AMOUNT_W-1:0]   amount = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  status;
	logic                  found;
	logic [COUNT_W-1:0]    key_count;
	logic [DISTINCT_W-1:0] distinct_keys;

	int unsigned send_idle_pct = 37;
	int unsigned recv_idle_pct = 72;
	int unsigned n_sent = 0;
	logic [KEY_W-1:0] key_pool[POOL_SIZE];

	count_table_model tally = new();

	integer_counted_set_table u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.key          (key),
		.amount       (amount),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.found        (found),
		.key_count    (key_count),
		.distinct_keys(distinct_keys)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side: check each accepted transaction, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tally.check_result('{status, found, key_count, distinct_keys});
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Valid stays high between back-to-back transactions; it only drops for a gap.
	task automatic send_op(logic [KIND_W-1:0] op, logic [KEY_W-1:0] k,
			logic [AMOUNT_W-1:0] amt);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		kind <= op;
		key <= k;
		amount <= amt;
		do
			@(posedge clk);
		while (!in_ready);
		tally.note_op(op, k, amt);
		n_sent++;
	endtask

	function automatic logic [AMOUNT_W-1:0] pick_amount();
		case ($urandom_range(9)) inside
			[0:3]: return $urandom_range(1, 20);
			4: return '0;
			5: return '1;
			[6:7]: return $urandom;
			8: return 32'hFFFF_FFFF - $urandom_range(0, 20);
			default: return $urandom_range(1, 1000);
		endcase
	endfunction

	task automatic send_random_op();
		int unsigned      r;
		logic [KEY_W-1:0] k;
		logic [KIND_W-1:0] op;
		r = $urandom_range(99);
		if (r < 40)
			op = KIND_ADD;
		else if (r < 60)
			op = KIND_SUB;
		else if (r < 68)
			op = KIND_REMOVE;
		else if (r < 88)
			op = KIND_QUERY;
		else if (r < 90)
			op = KIND_CLEAR;
		else
			op = KIND_W'($urandom_range(5, 7));
		// Mostly a small pool, so keys come back; a few fresh keys hit a full table.
		if ($urandom_range(9) == 0)
			k = $urandom;
		else
			k = key_pool[$urandom_range(POOL_SIZE - 1)];
		send_op(op, k, pick_amount());
	endtask

	initial begin
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'hFFFF_FFFF;
		key_pool[3] = 32'h0000_0000;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: absent keys, extremes, saturation, clearing and reuse of a slot.
		send_op(KIND_QUERY, 32'h0, 32'h0);
		send_op(KIND_ADD, 32'h0, 32'h0);
		send_op(KIND_SUB, 32'h0, 32'd5);
		send_op(KIND_REMOVE, 32'h0, 32'h0);
		send_op(KIND_ADD, 32'h8000_0000, 32'd1);
		send_op(KIND_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_op(KIND_ADD, 32'h7FFF_FFFF, 32'd1);
		send_op(KIND_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
		send_op(KIND_ADD, 32'hFFFF_FFFF, 32'd5);
		send_op(KIND_SUB, 32'hFFFF_FFFF, 32'd5);
		send_op(KIND_ADD, 32'hFFFF_FFFF, 32'd0);
		send_op(KIND_SUB, 32'hFFFF_FFFF, 32'd1);
		send_op(KIND_ADD, 32'hFFFF_FFFF, 32'd3);
		send_op(KIND_SUB, 32'hFFFF_FFFF, 32'd1);
		send_op(KIND_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(KIND_REMOVE, 32'h7FFF_FFFF, 32'h0);
		send_op(KIND_REMOVE, 32'h7FFF_FFFF, 32'h0);
		send_op(KIND_QUERY, 32'h8000_0000, 32'h0);
		send_op(3'd5, 32'h8000_0000, 32'hFFFF_FFFF);
		send_op(3'd6, 32'hFFFF_FFFF, 32'h0);
		send_op(3'd7, 32'h8000_0000, 32'h1234_5678);
		send_op(KIND_CLEAR, 32'h8000_0000, 32'h0);
		send_op(KIND_QUERY, 32'h8000_0000, 32'h0);
		send_op(KIND_ADD, 32'h8000_0000, 32'd2);
		send_op(KIND_ADD, 32'h0, 32'h5555_AAAA);

		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n == RANDOM_OPS / 3) begin
				send_idle_pct = 72;
				recv_idle_pct = 37;
			end else if (n == 2 * RANDOM_OPS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			send_random_op();
		end
		in_valid <= 1'b0;

		while (tally.pending.size() != 0)
			@(posedge clk);
		// Longest operation is a full scan of every slot.
		repeat (SLOTS + 10) @(posedge clk);

		$display("Sent %0d operations and checked %0d results; %0d slots taken,",
			n_sent, tally.n_checked, tally.used_slots);
		$display("%0d additions turned away by a full table.", tally.n_full);
		if (tally.errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Run stopped: no progress before the time limit.");
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== integer_counted_set_table.f =====
sv/icst_pkg.sv
sv/icst_ram.sv
sv/integer_counted_set_table.sv
sv/icst_chk.sv
dv/tb_top.sv
